/* rtl/core/ordered_list_engine_macros.svh */
// Assertion macros shared by the ordered list engine RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define OLST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered list engine: same-cycle check failed");

// next-cycle implication
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered list engine: next-cycle check failed");

`endif

/* rtl/core/olst_pkg.sv */
// Shared types and constants of the ordered list engine.
// No dependencies.
`timescale 1ns / 1ps

package olst_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [2:0] {
		KIND_APPEND    = 3'd0,
		KIND_HEAD      = 3'd1,
		KIND_INS_AFTER = 3'd2,
		KIND_DELETE    = 3'd3,
		KIND_COUNT     = 3'd4,
		KIND_READOUT   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_POSITION = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE,
		ST_WALK,
		ST_WR1,
		ST_WR2,
		ST_WR3,
		ST_EMIT
	} state_t;

	// which link fields of a node entry a write touches
	typedef struct packed {
		logic fwd;
		logic bwd;
	} link_mask_t;

endpackage

/* rtl/core/olst_ifs.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on nothing; widths come from the instantiating level.
`timescale 1ns / 1ps

interface olst_req_if #(
	parameter int VALUE_BITS = 32,
	parameter int POS_BITS   = 7
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            kind;
	logic [VALUE_BITS-1:0] value;
	logic [POS_BITS-1:0]   position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

interface olst_rsp_if #(
	parameter int VALUE_BITS = 32,
	parameter int CNT_BITS   = 7,
	parameter int TOTAL_BITS = 38
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            status;
	logic [CNT_BITS-1:0]   node_count;
	logic [TOTAL_BITS-1:0] total;
	logic [VALUE_BITS-1:0] element;
	logic                  last;

	modport source (output valid, status, node_count, total, element, last, input ready);
	modport sink   (input valid, status, node_count, total, element, last, output ready);
endinterface

/* rtl/core/ordered_list_engine.sv */
// Ordered list engine: one request at a time. Positional insert and delete walk the list,
// reading one linked node per cycle from the node memory, and readout gives one element
// per cycle while the output register is free to take it.
// Results leave through an output register, so the next request is taken while one waits.
// Reset clears head, tail, free list, length and sum at once; no clearing pass.
`timescale 1ns / 1ps

module ordered_list_engine
	import olst_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int IW = $clog2(CAPACITY + 1),
	localparam int TW = VALUE_BITS + $clog2(CAPACITY)
) (
	input  logic  clk,
	input  logic  arst_n,
	olst_req_if.sink   req,
	olst_rsp_if.source rsp
);

	logic                  out_free, emit, res_last;
	status_t               res_stat;
	logic [IW-1:0]         res_count;
	logic [TW-1:0]         res_total;
	logic [VALUE_BITS-1:0] res_elem;
	logic                  ovalid_q;

	olst_ctrl #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_kind    (req.kind),
		.req_value   (req.value),
		.req_position(req.position),
		.out_free    (out_free),
		.emit        (emit),
		.res_stat    (res_stat),
		.res_count   (res_count),
		.res_total   (res_total),
		.res_elem    (res_elem),
		.res_last    (res_last)
	);

	assign out_free  = !ovalid_q || rsp.ready;
	assign rsp.valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			rsp.status     <= res_stat;
			rsp.node_count <= res_count;
			rsp.total      <= res_total;
			rsp.element    <= res_elem;
			rsp.last       <= res_last;
		end
	end

endmodule

/* rtl/core/olst_node_mem.sv */
// Node pool storage: value memory and link memory, registered read.
// Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_node_mem
	import olst_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int IW = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [VALUE_BITS-1:0] rd_value,
	output logic [IW-1:0]         rd_fwd,
	output logic [IW-1:0]         rd_bwd,
	input  logic                  lw_en,
	input  link_mask_t            lw_mask,
	input  logic [AW-1:0]         lw_addr,
	input  logic [IW-1:0]         lw_fwd,
	input  logic [IW-1:0]         lw_bwd,
	input  logic                  vw_en,
	input  logic [AW-1:0]         vw_addr,
	input  logic [VALUE_BITS-1:0] vw_data
);

	logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
	logic [2*IW-1:0]       link_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (vw_en) begin
			val_mem[vw_addr] <= vw_data;
		end
		if (lw_en && lw_mask.fwd) begin
			link_mem[lw_addr][2*IW-1:IW] <= lw_fwd;
		end
		if (lw_en && lw_mask.bwd) begin
			link_mem[lw_addr][IW-1:0] <= lw_bwd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_value <= val_mem[rd_addr];
			rd_fwd   <= link_mem[rd_addr][2*IW-1:IW];
			rd_bwd   <= link_mem[rd_addr][IW-1:0];
		end
	end

endmodule

/* rtl/core/olst_ctrl.sv */
// List sequencer: decodes a request, walks the links through the node memory
// and writes them back. Depends on olst_pkg, olst_node_mem and the macros.
`timescale 1ns / 1ps
`include "ordered_list_engine_macros.svh"

module olst_ctrl
	import olst_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int IW = $clog2(CAPACITY + 1),
	localparam int TW = VALUE_BITS + $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [2:0]            req_kind,
	input  logic [VALUE_BITS-1:0] req_value,
	input  logic [IW-1:0]         req_position,
	input  logic                  out_free,
	output logic                  emit,
	output status_t               res_stat,
	output logic [IW-1:0]         res_count,
	output logic [TW-1:0]         res_total,
	output logic [VALUE_BITS-1:0] res_elem,
	output logic                  res_last
);

	localparam logic [IW-1:0] NIL = IW'(CAPACITY);
	localparam logic [IW-1:0] LAST_K = IW'(CAPACITY - 1);

	state_t state_q, state_d;

	logic [IW-1:0]         head_q, tail_q, fhead_q, fresh_q, len_q;
	logic [TW-1:0]         sum_q;
	kind_t                 kind_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IW-1:0]         pos_q, cur_q, nx_q, p_q, cnt_q, new_q, nfree_q;
	status_t               stat_q;

	logic                  rd_en;
	logic [IW-1:0]         rd_idx;
	logic [VALUE_BITS-1:0] rd_value;
	logic [IW-1:0]         rd_fwd, rd_bwd;
	logic                  lw_en, vw_en;
	link_mask_t            lw_mask;
	logic [IW-1:0]         lw_idx, lw_fwd, lw_bwd;

	logic          accept, full, fresh_alloc, pos_bad, hit, walk_end, fin, is_ins;
	logic [IW-1:0] posn;
	kind_t         req_k;

	olst_node_mem #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_idx[AW-1:0]),
		.rd_value(rd_value),
		.rd_fwd  (rd_fwd),
		.rd_bwd  (rd_bwd),
		.lw_en   (lw_en),
		.lw_mask (lw_mask),
		.lw_addr (lw_idx[AW-1:0]),
		.lw_fwd  (lw_fwd),
		.lw_bwd  (lw_bwd),
		.vw_en   (vw_en),
		.vw_addr (new_q[AW-1:0]),
		.vw_data (val_q)
	);

	assign req_ready   = (state_q == ST_IDLE);
	assign accept      = req_valid && req_ready;
	assign req_k       = kind_t'(req_kind);
	assign full        = (len_q == NIL);
	// free list is the recycled stack, then the never-used nodes from fresh_q up
	assign fresh_alloc = (fhead_q == fresh_q);
	assign posn        = (req_position == '0) ? IW'(1) : req_position;
	assign pos_bad     = (posn > len_q) || (head_q == NIL);
	assign hit         = (rd_value == val_q);
	assign walk_end    = (rd_fwd == NIL) || (cnt_q == LAST_K);
	assign fin         = walk_end;
	assign is_ins      = (kind_q == KIND_APPEND) || (kind_q == KIND_HEAD)
		|| (kind_q == KIND_INS_AFTER);

	assign res_count = len_q;
	assign res_total = sum_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_k)
						KIND_APPEND, KIND_HEAD: begin
							if (full) state_d = ST_EMIT;
							else if (!fresh_alloc) state_d = ST_FREE;
							else state_d = ST_WR1;
						end
						KIND_INS_AFTER: begin
							if (full || pos_bad) state_d = ST_EMIT;
							else if (!fresh_alloc) state_d = ST_FREE;
							else state_d = ST_WALK;
						end
						KIND_DELETE, KIND_READOUT: begin
							state_d = (head_q == NIL) ? ST_EMIT : ST_WALK;
						end
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_FREE: state_d = (kind_q == KIND_INS_AFTER) ? ST_WALK : ST_WR1;
			ST_WALK: begin
				case (kind_q)
					KIND_INS_AFTER: if (cnt_q == pos_q) state_d = ST_WR1;
					KIND_DELETE: begin
						if (hit) state_d = ST_WR1;
						else if (walk_end) state_d = ST_EMIT;
					end
					default: if (out_free && fin) state_d = ST_IDLE;
				endcase
			end
			ST_WR1: state_d = ST_WR2;
			ST_WR2: begin
				state_d = (kind_q == KIND_APPEND || kind_q == KIND_HEAD) ? ST_EMIT : ST_WR3;
			end
			ST_WR3: state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and result strobes
	always_comb begin
		rd_en    = 1'b0;
		rd_idx   = head_q;
		lw_en    = 1'b0;
		lw_mask  = '{fwd: 1'b1, bwd: 1'b1};
		lw_idx   = new_q;
		lw_fwd   = NIL;
		lw_bwd   = NIL;
		vw_en    = 1'b0;
		emit     = 1'b0;
		res_stat = stat_q;
		res_elem = '0;
		res_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_k)
						KIND_APPEND, KIND_HEAD: begin
							if (!full && !fresh_alloc) begin
								rd_en  = 1'b1;
								rd_idx = fhead_q;
							end
						end
						KIND_INS_AFTER: begin
							if (!full && !pos_bad) begin
								rd_en  = 1'b1;
								rd_idx = fresh_alloc ? head_q : fhead_q;
							end
						end
						KIND_DELETE, KIND_READOUT: rd_en = (head_q != NIL);
						default: rd_en = 1'b0;
					endcase
				end
			end
			ST_FREE: rd_en = (kind_q == KIND_INS_AFTER);
			ST_WALK: begin
				rd_idx = rd_fwd;
				case (kind_q)
					KIND_INS_AFTER: rd_en = (cnt_q != pos_q);
					KIND_DELETE:    rd_en = !hit && !walk_end;
					default: begin
						if (out_free) begin
							emit     = 1'b1;
							res_stat = STAT_OK;
							res_elem = rd_value;
							res_last = fin;
							rd_en    = !fin;
						end
					end
				endcase
			end
			ST_WR1: begin
				if (kind_q == KIND_DELETE) begin
					// predecessor takes over the forward link
					lw_en   = (p_q != NIL);
					lw_idx  = p_q;
					lw_mask = '{fwd: 1'b1, bwd: 1'b0};
					lw_fwd  = nx_q;
				end else begin
					vw_en = 1'b1;
					lw_en = 1'b1;
					case (kind_q)
						KIND_APPEND: begin
							lw_fwd = NIL;
							lw_bwd = tail_q;
						end
						KIND_HEAD: begin
							lw_fwd = head_q;
							lw_bwd = NIL;
						end
						default: begin
							lw_fwd = nx_q;
							lw_bwd = cur_q;
						end
					endcase
				end
			end
			ST_WR2: begin
				case (kind_q)
					KIND_APPEND: begin
						lw_en   = (tail_q != NIL);
						lw_idx  = tail_q;
						lw_mask = '{fwd: 1'b1, bwd: 1'b0};
						lw_fwd  = new_q;
					end
					KIND_HEAD: begin
						lw_en   = (head_q != NIL);
						lw_idx  = head_q;
						lw_mask = '{fwd: 1'b0, bwd: 1'b1};
						lw_bwd  = new_q;
					end
					KIND_INS_AFTER: begin
						lw_en   = (nx_q != NIL);
						lw_idx  = nx_q;
						lw_mask = '{fwd: 1'b0, bwd: 1'b1};
						lw_bwd  = new_q;
					end
					default: begin
						lw_en   = (nx_q != NIL);
						lw_idx  = nx_q;
						lw_mask = '{fwd: 1'b0, bwd: 1'b1};
						lw_bwd  = p_q;
					end
				endcase
			end
			ST_WR3: begin
				lw_en   = 1'b1;
				lw_idx  = cur_q;
				lw_mask = '{fwd: 1'b1, bwd: 1'b0};
				lw_fwd  = (kind_q == KIND_DELETE) ? fhead_q : new_q;
			end
			ST_EMIT: emit = out_free;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= NIL;
			tail_q  <= NIL;
			fhead_q <= '0;
			fresh_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && !full && fresh_alloc
				&& (req_k == KIND_APPEND || req_k == KIND_HEAD
				|| (req_k == KIND_INS_AFTER && !pos_bad))) begin
				fresh_q <= fresh_q + IW'(1);
			end
			if (state_q == ST_WALK && kind_q == KIND_DELETE && hit) begin
				sum_q <= sum_q - {{(TW-VALUE_BITS){rd_value[VALUE_BITS-1]}}, rd_value};
				len_q <= len_q - IW'(1);
			end
			case (state_q)
				ST_WR1: begin
					if (kind_q == KIND_DELETE) begin
						if (p_q == NIL) head_q <= nx_q;
					end else begin
						fhead_q <= nfree_q;
						len_q   <= len_q + IW'(1);
						sum_q   <= sum_q + {{(TW-VALUE_BITS){val_q[VALUE_BITS-1]}}, val_q};
					end
				end
				ST_WR2: begin
					case (kind_q)
						KIND_APPEND: begin
							tail_q <= new_q;
							if (tail_q == NIL) head_q <= new_q;
						end
						KIND_HEAD: begin
							head_q <= new_q;
							if (head_q == NIL) tail_q <= new_q;
						end
						KIND_INS_AFTER: if (nx_q == NIL) tail_q <= new_q;
						default: if (nx_q == NIL) tail_q <= p_q;
					endcase
				end
				ST_WR3: if (kind_q == KIND_DELETE) fhead_q <= cur_q;
				default: ;
			endcase
		end
	end

	// request context and walk registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_q <= rd_idx;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q  <= req_k;
					val_q   <= req_value;
					pos_q   <= posn;
					new_q   <= fhead_q;
					nfree_q <= fresh_q + IW'(1);
					cnt_q   <= (req_k == KIND_INS_AFTER) ? IW'(1) : '0;
					case (req_k)
						KIND_APPEND, KIND_HEAD: stat_q <= full ? STAT_FULL : STAT_OK;
						KIND_INS_AFTER: begin
							if (full) stat_q <= STAT_FULL;
							else if (pos_bad) stat_q <= STAT_POSITION;
							else stat_q <= STAT_OK;
						end
						KIND_DELETE, KIND_READOUT: begin
							stat_q <= (head_q == NIL) ? STAT_EMPTY : STAT_OK;
						end
						default: stat_q <= STAT_OK;
					endcase
				end
			end
			ST_FREE: nfree_q <= rd_fwd;
			ST_WALK: begin
				if (rd_en) cnt_q <= cnt_q + IW'(1);
				if (kind_q == KIND_INS_AFTER && cnt_q == pos_q) nx_q <= rd_fwd;
				if (kind_q == KIND_DELETE) begin
					if (hit) begin
						p_q  <= rd_bwd;
						nx_q <= rd_fwd;
					end else if (walk_end) begin
						stat_q <= STAT_NOTFOUND;
					end
				end
			end
			default: ;
		endcase
	end

	`OLST_ASSERT_NOW(a_emit_free, clk, arst_n, emit, out_free)
	`OLST_ASSERT_NOW(a_empty_head, clk, arst_n, state_q == ST_IDLE, (head_q == NIL) == (len_q == '0))
	`OLST_ASSERT_NEXT(a_ins_grows, clk, arst_n, state_q == ST_WR1 && is_ins, len_q == $past(len_q) + IW'(1))
	`OLST_ASSERT_NOW(a_read_no_write, clk, arst_n, rd_en, !lw_en && !vw_en)

endmodule
